FILE: rtl/core/simple_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Simple moving average assertion macros
// Concurrent assertion helpers used by the block's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/sma_pkg.sv
// ----------------------------------------------------------------------------
// Simple moving average package
// Controller states, command and status bundles, and fixed constants.
// ----------------------------------------------------------------------------
package sma_pkg;

    // Width of the window length register and its value after reset.
    localparam int unsigned WLEN_W = 6;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } sma_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_start;
        logic out_load;
    } sma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } sma_status_t;

endpackage

FILE: rtl/core/sma_if.sv
// ----------------------------------------------------------------------------
// Simple moving average channel interfaces
// Valid/ready channels for incoming samples and outgoing averages.
// ----------------------------------------------------------------------------
interface sma_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_of_series;

    modport source (output valid, output sample, output start_of_series, input ready);
    modport sink (input valid, input sample, input start_of_series, output ready);
endinterface

interface sma_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] average;
    logic                           window_full;

    modport source (output valid, output average, output window_full, input ready);
    modport sink (input valid, input average, input window_full, output ready);
endinterface

FILE: rtl/core/sma_div.sv
// ----------------------------------------------------------------------------
// Simple moving average divider
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module sma_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic signed [DIVIDEND_W-1:0] quotient,
    output logic                         done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVISOR_W:0]    rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  divisor_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [DIVISOR_W:0]    rem_shift;

    assign rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        count_next   = count_reg;
        if (start)
        begin
            // The magnitude of the most negative sum still fits unsigned.
            quo_next     = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next     = '0;
            divisor_next = divisor;
            neg_next     = dividend[DIVIDEND_W-1];
            count_next   = CNT_W'(DIVIDEND_W);
        end
        else if (count_reg != '0)
        begin
            if (rem_shift >= {1'b0, divisor_reg})
            begin
                rem_next = rem_shift - {1'b0, divisor_reg};
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    assign quotient = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);
    assign done     = (count_reg == '0);

endmodule

FILE: rtl/core/sma_datapath.sv
// ----------------------------------------------------------------------------
// Simple moving average datapath
// Sample history memory, pointers, running sum, divider and result register.
// ----------------------------------------------------------------------------
module sma_datapath #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sma_pkg::sma_cmd_t                cmd,
    output sma_pkg::sma_status_t             status,
    input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
    input  logic                             in_start_of_series,
    input  logic                             cfg_we,
    input  logic [sma_pkg::WLEN_W-1:0]       cfg_wdata,
    output logic signed [SAMPLE_WIDTH-1:0]   average,
    output logic                             window_full
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
    localparam int EXT_W = SUM_W - SAMPLE_WIDTH;
    localparam int ADR_W = LEN_W + 1;

    logic [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];

    logic [sma_pkg::WLEN_W-1:0] wlen_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic [PTR_W-1:0]           wp_next;
    logic [LEN_W-1:0]           filled_reg;
    logic [LEN_W-1:0]           filled_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       full_reg;
    logic                       full_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                       sos_reg;
    logic [SAMPLE_WIDTH-1:0]    rd_data_reg;
    logic signed [SAMPLE_WIDTH-1:0] average_reg;
    logic                       window_full_reg;

    logic [LEN_W-1:0]        eff_len;
    logic [PTR_W-1:0]        wp_eff;
    logic [LEN_W-1:0]        filled_eff;
    logic signed [SUM_W-1:0] sum_eff;
    logic                    was_full;
    logic [ADR_W-1:0]        wp_ext;
    logic [ADR_W-1:0]        len_ext;
    logic [ADR_W-1:0]        oldest_wide;
    logic [PTR_W-1:0]        rd_addr;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] quotient;

    // Zero means one sample; anything beyond the store saturates.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(wlen_reg) > MAX_WINDOW)
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = LEN_W'(wlen_reg);
        end
    end

    // A new series sees an empty history.
    assign wp_eff     = sos_reg ? '0 : wp_reg;
    assign filled_eff = sos_reg ? '0 : filled_reg;
    assign sum_eff    = sos_reg ? '0 : sum_reg;
    assign was_full   = (filled_eff >= eff_len);

    assign wp_ext      = ADR_W'(wp_eff);
    assign len_ext     = ADR_W'(eff_len);
    assign oldest_wide = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                             : (wp_ext + ADR_W'(MAX_WINDOW) - len_ext);
    assign rd_addr     = oldest_wide[PTR_W-1:0];

    assign new_ext = {{EXT_W{sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};
    assign old_ext = was_full ? {{EXT_W{rd_data_reg[SAMPLE_WIDTH-1]}}, rd_data_reg} : '0;

    always_comb
    begin
        sum_next    = sum_eff - old_ext + new_ext;
        filled_next = was_full ? eff_len : (filled_eff + 1'b1);
        full_next   = (filled_next == eff_len);
        if (wp_eff == PTR_W'(MAX_WINDOW - 1))
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= sma_pkg::WLEN_RESET;
            wp_reg     <= '0;
            filled_reg <= '0;
            sum_reg    <= '0;
            full_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            // A new window length starts a new series.
            wlen_reg   <= cfg_wdata;
            wp_reg     <= '0;
            filled_reg <= '0;
            sum_reg    <= '0;
        end
        else if (cmd.update)
        begin
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            sum_reg    <= sum_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            sos_reg    <= in_start_of_series;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.update)
        begin
            mem[wp_eff] <= sample_reg;
        end
        if (cmd.out_load)
        begin
            average_reg     <= full_reg ? quotient[SAMPLE_WIDTH-1:0] : '0;
            window_full_reg <= full_reg;
        end
    end

    sma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (eff_len),
        .quotient (quotient),
        .done     (status.div_done)
    );

    assign average     = average_reg;
    assign window_full = window_full_reg;

endmodule

FILE: rtl/core/sma_ctrl.sv
// ----------------------------------------------------------------------------
// Simple moving average controller
// Sequences one sample through read, update, divide and result load.
// ----------------------------------------------------------------------------
module sma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sma_pkg::sma_cmd_t    cmd,
    input  sma_pkg::sma_status_t status
);

    sma_pkg::sma_state_t state_reg;
    sma_pkg::sma_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    // The result register may be refilled once its transfer completes.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sma_pkg::ST_READ;
                end
            end
            sma_pkg::ST_READ:   state_next = sma_pkg::ST_UPDATE;
            sma_pkg::ST_UPDATE: state_next = sma_pkg::ST_START;
            sma_pkg::ST_START:  state_next = sma_pkg::ST_DIVIDE;
            sma_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = sma_pkg::ST_FINISH;
                end
            end
            sma_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sma_pkg::ST_IDLE;
                end
            end
            default: state_next = sma_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            sma_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            sma_pkg::ST_READ:   cmd.read      = 1'b1;
            sma_pkg::ST_UPDATE: cmd.update    = 1'b1;
            sma_pkg::ST_START:  cmd.div_start = 1'b1;
            sma_pkg::ST_FINISH: cmd.out_load  = out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sma_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/simple_moving_average.sv
// ----------------------------------------------------------------------------
// Simple moving average
// Boxcar mean of the newest window_length signed fixed-point samples.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Payload                          | Handshake
//  ----------+-----------+----------------------------------+------------
//  samples   | in        | sample, start_of_series          | valid/ready
//  averages  | out       | average, window_full             | valid/ready
//  cfg       | in        | window_length (cfg_wdata)        | cfg_we only
//
// The restoring divider works on SUM_W = SAMPLE_WIDTH + clog2(MAX_WINDOW)
// bits and produces one quotient bit per cycle. The block works on one sample
// at a time and asserts ready on the samples channel only while it is idle.
// Reset clears the pointers, fill count and running sum and sets the window
// length to five; the history memory is not cleared and needs no sweep.
// A result waiting on a stalled averages channel holds its value; the next
// sample may be transferred in the meantime, and its result is loaded only
// once the waiting one has been taken.
//
`include "simple_moving_average_defines.svh"

module simple_moving_average #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sma_in_if.sink                     samples,
    sma_out_if.source                  averages,
    input  logic                       cfg_we,
    input  logic [sma_pkg::WLEN_W-1:0] cfg_wdata
);

    // Command and status bundles between the controller and the datapath.
    sma_pkg::sma_cmd_t    cmd;
    sma_pkg::sma_status_t status;

    // The controller owns the handshakes and the sequencing of one sample.
    sma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (averages.valid),
        .out_ready (averages.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the history, running sum, divider and result.
    sma_datapath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .in_sample          (samples.sample),
        .in_start_of_series (samples.start_of_series),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .average            (averages.average),
        .window_full        (averages.window_full)
    );

    // Only one sample is in flight: a transfer closes the input side.
    `SMA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, samples.valid && samples.ready,
        !samples.ready, "sample accepted while another is in flight")

    // The result is never loaded before the divider has finished.
    `SMA_ASSERT_SAME(a_load_after_divide, clk, rst_n, cmd.out_load, status.div_done,
        "result loaded while divider busy")

    // A pending result is never overwritten.
    `SMA_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load,
        !averages.valid || averages.ready, "pending result overwritten")

    // Before the window fills, the average reads zero.
    `SMA_ASSERT_SAME(a_zero_when_not_full, clk, rst_n,
        averages.valid && !averages.window_full, averages.average == '0,
        "nonzero average before window full")

endmodule
